FILE: src/rcf_pkg.sv
// Shared types, constants and helper functions for the RGB channel fade block.
`timescale 1ns / 1ps

package rcf_pkg;

	// Pixel and table geometry
	localparam int PIXEL_W    = 32;
	localparam int INDEX_BITS = 5;
	localparam int LOW_BITS   = 8 - INDEX_BITS;
	localparam int DEPTH      = 1 << INDEX_BITS;
	localparam int NUM_CH     = 3;
	localparam int POS_W      = 5;
	localparam int LOSS_W     = 3;
	localparam int PCT_W      = 8;
	localparam int LEVEL_W    = 8;

	// Channel slots
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// Fade arithmetic
	localparam int PCT_UNITY   = 100;
	localparam int PCT_MAX     = 200;
	localparam int FULL_SCALE  = 255;
	localparam int NUM_W       = 15;   // holds up to 255*100
	localparam int RECIP       = 5243; // ceil(2^19 / 100)
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = NUM_W + RECIP_W;

	// APB register map
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_RED_PCT   = 3'd0,
		REG_GREEN_PCT = 3'd1,
		REG_BLUE_PCT  = 3'd2,
		REG_RED_POS   = 3'd3,
		REG_GREEN_POS = 3'd4,
		REG_BLUE_POS  = 3'd5,
		REG_LOSSES    = 3'd6
	} rcf_reg_t;

	// Fade table write port, shared by all three lanes
	typedef struct packed {
		logic                                  en;
		logic [INDEX_BITS-1:0]                 addr;
		logic [NUM_CH-1:0][LEVEL_W-1:0]        level;
	} rcf_wr_t;

	// First fade stage: offset plus numerator still to be divided by 100
	typedef struct packed {
		logic [LEVEL_W-1:0] base;
		logic [NUM_W-1:0]   num;
	} rcf_prep_t;

	function automatic rcf_prep_t rcf_prep(input logic [INDEX_BITS-1:0] x,
		input logic [PCT_W-1:0] pct);
		logic [LEVEL_W-1:0] c;
		logic [PCT_W-1:0]   p;
		logic [15:0]        m;
		rcf_prep_t          r;
		c = {x, {LOW_BITS{1'b1}}};
		p = (pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct;
		if (p <= PCT_W'(PCT_UNITY)) begin
			r.base = '0;
			m = 16'(c) * 16'(p);
		end else begin
			r.base = c;
			m = 16'(LEVEL_W'(FULL_SCALE) - c) * 16'(p - PCT_W'(PCT_UNITY));
		end
		r.num = m[NUM_W-1:0];
		return r;
	endfunction

endpackage

FILE: src/rcf_fill.sv
// Fade table sequencer: sweeps all indices and computes faded levels for each channel.
`timescale 1ns / 1ps

module rcf_fill (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic [rcf_pkg::NUM_CH-1:0][rcf_pkg::PCT_W-1:0] pct,
	output rcf_pkg::rcf_wr_t                             wr,
	output logic                                         busy
);

	logic                                               issue_q;
	logic [rcf_pkg::INDEX_BITS-1:0]                     cnt_q;
	logic                                               vld_s1;
	logic                                               vld_s2;
	logic [rcf_pkg::INDEX_BITS-1:0]                     addr_s1;
	logic [rcf_pkg::INDEX_BITS-1:0]                     addr_s2;
	rcf_pkg::rcf_prep_t [rcf_pkg::NUM_CH-1:0]           prep_s1;
	logic [rcf_pkg::NUM_CH-1:0][rcf_pkg::LEVEL_W-1:0]   base_s2;
	logic [rcf_pkg::NUM_CH-1:0][rcf_pkg::PROD_W-1:0]    prod_s2;
	logic                                               wr_en_q;
	logic [rcf_pkg::INDEX_BITS-1:0]                     wr_addr_q;
	logic [rcf_pkg::NUM_CH-1:0][rcf_pkg::LEVEL_W-1:0]   wr_level_q;

	// Sweep counter; reset starts a fill straight away
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b1;
			cnt_q   <= '0;
		end else if (start) begin
			issue_q <= 1'b1;
			cnt_q   <= '0;
		end else if (issue_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == rcf_pkg::INDEX_BITS'(rcf_pkg::DEPTH - 1)) begin
				issue_q <= 1'b0;
			end
		end
	end

	// Stage valids and write enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			wr_en_q <= 1'b0;
		end else begin
			vld_s1  <= issue_q;
			vld_s2  <= vld_s1;
			wr_en_q <= vld_s2;
		end
	end

	// Stage 1: offset and numerator (one 8x8 product per channel)
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		for (int i = 0; i < rcf_pkg::NUM_CH; i++) begin
			prep_s1[i] <= rcf_pkg::rcf_prep(cnt_q, pct[i]);
		end
	end

	// Stage 2: divide by 100 through a reciprocal product
	always_ff @(posedge clk) begin
		addr_s2 <= addr_s1;
		for (int i = 0; i < rcf_pkg::NUM_CH; i++) begin
			base_s2[i] <= prep_s1[i].base;
			prod_s2[i] <= rcf_pkg::PROD_W'(prep_s1[i].num) *
				rcf_pkg::PROD_W'(rcf_pkg::RECIP);
		end
	end

	// Stage 3: add offset, present to table write port
	always_ff @(posedge clk) begin
		wr_addr_q <= addr_s2;
		for (int i = 0; i < rcf_pkg::NUM_CH; i++) begin
			wr_level_q[i] <= base_s2[i] +
				prod_s2[i][rcf_pkg::RECIP_SHIFT +: rcf_pkg::LEVEL_W];
		end
	end

	assign wr.en    = wr_en_q;
	assign wr.addr  = wr_addr_q;
	assign wr.level = wr_level_q;
	assign busy     = issue_q | vld_s1 | vld_s2 | wr_en_q;

endmodule

FILE: src/rcf_lane.sv
// One color channel: index extraction, fade table memory and repacking.
`timescale 1ns / 1ps

module rcf_lane (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [rcf_pkg::INDEX_BITS-1:0]      wr_addr,
	input  logic [rcf_pkg::LEVEL_W-1:0]         wr_level,
	input  logic                                rd_en,
	input  logic [rcf_pkg::PIXEL_W-1:0]         pixel,
	input  logic [rcf_pkg::POS_W-1:0]           pos,
	input  logic [rcf_pkg::LOSS_W-1:0]          loss,
	output logic [rcf_pkg::PIXEL_W-1:0]         chan_out
);

	logic [rcf_pkg::LEVEL_W-1:0]    mem [rcf_pkg::DEPTH];
	logic [rcf_pkg::LEVEL_W-1:0]    rd_level_q;
	logic [rcf_pkg::PIXEL_W-1:0]    shifted;
	logic [rcf_pkg::LEVEL_W-1:0]    field;
	logic [rcf_pkg::LEVEL_W-1:0]    full;
	logic [rcf_pkg::INDEX_BITS-1:0] idx;
	logic [rcf_pkg::LEVEL_W-1:0]    level_dn;

	// Extract channel field, rescale to 8 bits, keep top index bits
	always_comb begin
		shifted = pixel >> pos;
		field   = shifted[rcf_pkg::LEVEL_W-1:0] & (rcf_pkg::LEVEL_W'(8'hFF) >> loss);
		full    = field << loss;
		idx     = full[rcf_pkg::LEVEL_W-1 -: rcf_pkg::INDEX_BITS];
	end

	// Fade table: written by the fill sweep, read on accepted transactions
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_level;
		end
		if (rd_en) begin
			rd_level_q <= mem[idx];
		end
	end

	// Repack: drop low bits, move to channel position
	always_comb begin
		level_dn = rd_level_q >> loss;
		chan_out = rcf_pkg::PIXEL_W'(level_dn) << pos;
	end

endmodule

FILE: src/rgb_channel_fade.sv
// Top level of the RGB per-channel fade block: register file, pipeline control, lanes.
//
//  channel   | direction | handshake         | payload
//  ----------+-----------+-------------------+-----------------------------
//  input     | in        | in_valid/in_stall | pixel_in[31:0]
//  output    | out       | out_valid/out_stall | pixel_out[31:0]
//  config    | in/out    | APB psel/penable  | paddr[4:0], pwdata/prdata
//
//  One pixel per clock unless stalled; each pixel passes the table read, then the output register.
//  After reset, and after any write to a percent register, a fill sweep
//  rewrites the 32-entry fade tables with in_stall held high.
//  Output stall holds the output register; a new pixel is still taken as long
//  as the table read stage can move on.
`timescale 1ns / 1ps

module rgb_channel_fade (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rcf_pkg::PIXEL_W-1:0]  pixel_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rcf_pkg::PIXEL_W-1:0]  pixel_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rcf_pkg::ADDR_W-1:0]   paddr,
	input  logic [rcf_pkg::DATA_W-1:0]   pwdata,
	output logic [rcf_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	logic [rcf_pkg::NUM_CH-1:0][rcf_pkg::PCT_W-1:0]  pct_q;
	logic [rcf_pkg::NUM_CH-1:0][rcf_pkg::POS_W-1:0]  pos_q;
	logic [rcf_pkg::NUM_CH*rcf_pkg::LOSS_W-1:0]      losses_q;
	logic [rcf_pkg::NUM_CH-1:0][rcf_pkg::LOSS_W-1:0] loss;
	logic [2:0]                                      reg_idx;
	logic                                            cfg_wr;
	logic                                            fill_start;
	logic                                            busy;
	rcf_pkg::rcf_wr_t                                tbl_wr;
	logic                                            accept;
	logic                                            adv;
	logic                                            s1_free;
	logic                                            vld_s1;
	logic                                            out_valid_q;
	logic [rcf_pkg::PIXEL_W-1:0]                     pixel_out_q;
	logic [rcf_pkg::NUM_CH-1:0][rcf_pkg::PIXEL_W-1:0] chan;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q[rcf_pkg::CH_RED]   <= rcf_pkg::PCT_W'(rcf_pkg::PCT_UNITY);
			pct_q[rcf_pkg::CH_GREEN] <= rcf_pkg::PCT_W'(rcf_pkg::PCT_UNITY);
			pct_q[rcf_pkg::CH_BLUE]  <= rcf_pkg::PCT_W'(rcf_pkg::PCT_UNITY);
			pos_q[rcf_pkg::CH_RED]   <= 5'd11;
			pos_q[rcf_pkg::CH_GREEN] <= 5'd5;
			pos_q[rcf_pkg::CH_BLUE]  <= 5'd0;
			losses_q                 <= 9'd211;
		end else if (cfg_wr) begin
			case (reg_idx)
				rcf_pkg::REG_RED_PCT:   pct_q[rcf_pkg::CH_RED]   <= pwdata[7:0];
				rcf_pkg::REG_GREEN_PCT: pct_q[rcf_pkg::CH_GREEN] <= pwdata[7:0];
				rcf_pkg::REG_BLUE_PCT:  pct_q[rcf_pkg::CH_BLUE]  <= pwdata[7:0];
				rcf_pkg::REG_RED_POS:   pos_q[rcf_pkg::CH_RED]   <= pwdata[4:0];
				rcf_pkg::REG_GREEN_POS: pos_q[rcf_pkg::CH_GREEN] <= pwdata[4:0];
				rcf_pkg::REG_BLUE_POS:  pos_q[rcf_pkg::CH_BLUE]  <= pwdata[4:0];
				rcf_pkg::REG_LOSSES:    losses_q                 <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			rcf_pkg::REG_RED_PCT:   prdata = 32'(pct_q[rcf_pkg::CH_RED]);
			rcf_pkg::REG_GREEN_PCT: prdata = 32'(pct_q[rcf_pkg::CH_GREEN]);
			rcf_pkg::REG_BLUE_PCT:  prdata = 32'(pct_q[rcf_pkg::CH_BLUE]);
			rcf_pkg::REG_RED_POS:   prdata = 32'(pos_q[rcf_pkg::CH_RED]);
			rcf_pkg::REG_GREEN_POS: prdata = 32'(pos_q[rcf_pkg::CH_GREEN]);
			rcf_pkg::REG_BLUE_POS:  prdata = 32'(pos_q[rcf_pkg::CH_BLUE]);
			rcf_pkg::REG_LOSSES:    prdata = 32'(losses_q);
			default:                prdata = '0;
		endcase
	end

	// Loss fields: red on top, blue at the bottom
	assign loss[rcf_pkg::CH_RED]   = losses_q[8:6];
	assign loss[rcf_pkg::CH_GREEN] = losses_q[5:3];
	assign loss[rcf_pkg::CH_BLUE]  = losses_q[2:0];

	// A percent change invalidates the fade tables
	assign fill_start = cfg_wr & ((reg_idx == rcf_pkg::REG_RED_PCT) |
		(reg_idx == rcf_pkg::REG_GREEN_PCT) | (reg_idx == rcf_pkg::REG_BLUE_PCT));

	rcf_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fill_start),
		.pct    (pct_q),
		.wr     (tbl_wr),
		.busy   (busy)
	);

	// Pipeline control: table read stage then output register
	assign adv      = ~out_valid_q | ~out_stall;
	assign s1_free  = ~vld_s1 | adv;
	assign in_stall = busy | ~s1_free;
	assign accept   = in_valid & ~in_stall;

	for (genvar g = 0; g < rcf_pkg::NUM_CH; g++) begin : g_lane
		rcf_lane u_lane (
			.clk      (clk),
			.wr_en    (tbl_wr.en),
			.wr_addr  (tbl_wr.addr),
			.wr_level (tbl_wr.level[g]),
			.rd_en    (accept),
			.pixel    (pixel_in),
			.pos      (pos_q[g]),
			.loss     (loss[g]),
			.chan_out (chan[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				vld_s1 <= accept;
			end
			if (adv) begin
				out_valid_q <= vld_s1;
			end
		end
	end

	// Output data: channels merged by OR
	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			pixel_out_q <= chan[rcf_pkg::CH_RED] | chan[rcf_pkg::CH_GREEN] |
				chan[rcf_pkg::CH_BLUE];
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;

endmodule
